// File: rtl/core/i8dot_pkg.sv
`default_nettype none
package i8dot_pkg;

  typedef struct packed {
    logic [31:0]       activation;
    logic signed [7:0] weight;
    logic [31:0]       row_scale;
    logic [31:0]       row_bias;
  } in_beat_t;

  typedef struct packed {
    logic [31:0] row_value;
    logic [15:0] row_number;
  } out_beat_t;

  // register indexes
  localparam logic [0:0] REG_ROW_LENGTH = 1'b0;
  localparam logic [0:0] REG_ROW_COUNT  = 1'b1;

  localparam logic [31:0] CANON_NAN = 32'h7FC00000;

  // datapath operation selects
  typedef enum logic [1:0] {
    OP_MUL_ACT = 2'd0,  // prod = act * w
    OP_ADD_SUM = 2'd1,  // sum = sum + prod
    OP_MUL_SCL = 2'd2,  // tmp = sum * scale
    OP_ADD_BIA = 2'd3   // res = tmp + bias
  } op_t;

  typedef struct packed {
    logic load;   // capture input beat
    logic exec;   // run op this cycle
    op_t  op;
    logic clear;  // zero the running sum
  } dp_cmd_t;

  // fp32 multiply, round to nearest even, canonical nan
  function automatic logic [31:0] fmul(input logic [31:0] a, input logic [31:0] b);
    logic        sa, sb, s;
    logic [7:0]  ea, eb;
    logic [22:0] fa, fb;
    logic [23:0] ma, mb;
    logic [47:0] p;
    logic signed [10:0] e;
    logic [5:0]  lza, lzb;
    logic [49:0] w;
    logic        st, g, lsb;
    logic [24:0] m;
    logic [10:0] sh;
    integer i;
    logic [31:0] r;
    sa = a[31]; sb = b[31]; s = sa ^ sb;
    ea = a[30:23]; eb = b[30:23]; fa = a[22:0]; fb = b[22:0];
    r = 32'd0;
    if ((ea == 8'hFF && fa != 0) || (eb == 8'hFF && fb != 0)) begin
      r = CANON_NAN;
    end else if (ea == 8'hFF || eb == 8'hFF) begin
      if ((ea == 0 && fa == 0) || (eb == 0 && fb == 0)) r = CANON_NAN;
      else r = {s, 8'hFF, 23'd0};
    end else if ((ea == 0 && fa == 0) || (eb == 0 && fb == 0)) begin
      r = {s, 31'd0};
    end else begin
      ma = {(ea != 0), fa}; mb = {(eb != 0), fb};
      lza = 6'd0; lzb = 6'd0;
      for (i = 23; i >= 0; i--) if (ma[i]) lza = 6'(23 - i);
      for (i = 23; i >= 0; i--) if (mb[i]) lzb = 6'(23 - i);
      // leading one search above picks the lowest set bit (last assignment wins low i),
      // so redo from bottom to pick the topmost set bit
      lza = 6'd0; lzb = 6'd0;
      for (i = 0; i <= 23; i++) if (ma[i]) lza = 6'(23 - i);
      for (i = 0; i <= 23; i++) if (mb[i]) lzb = 6'(23 - i);
      ma = ma << lza; mb = mb << lzb;
      p = ma * mb;
      e = 11'(signed'({3'd0, (ea == 0) ? 8'd1 : ea})) + 11'(signed'({3'd0,
          (eb == 0) ? 8'd1 : eb})) - 11'sd127 - 11'(signed'({5'd0, lza}))
          - 11'(signed'({5'd0, lzb}));
      // normalize p to bit 47
      if (!p[47]) p = p << 1; else e = e + 11'sd1;
      // p[47] is lead, e is exponent of p[47] as 2^(e-127)
      w = {p, 2'b00};
      if (e <= 0) begin
        sh = 11'(1 - e);
        if (sh > 11'd49) begin
          st = |w; w = 50'd0;
        end else begin
          st = 1'b0;
          for (i = 0; i < 50; i++) if (i < sh && w[i]) st = 1'b1;
          w = w >> sh;
        end
        e = 11'sd0;
      end else st = 1'b0;
      // mantissa 24 bits w[49:26], guard w[25], rest sticky
      g = w[25]; st = st | (|w[24:0]); lsb = w[26];
      m = {1'b0, w[49:26]} + {24'd0, (g & (st | lsb))};
      if (e == 0) begin
        // subnormal: may round up to normal
        r = {s, (m[23] ? 8'd1 : 8'd0), m[22:0]};
      end else begin
        if (m[24]) begin m = m >> 1; e = e + 11'sd1; end
        if (e >= 11'sd255) r = {s, 8'hFF, 23'd0};
        else r = {s, e[7:0], m[22:0]};
      end
    end
    return r;
  endfunction

  // fp32 add, round to nearest even, canonical nan
  function automatic logic [31:0] fadd(input logic [31:0] a, input logic [31:0] b);
    logic [31:0] x, y, r;
    logic [7:0]  ex, ey;
    logic [26:0] mx, my, mr;
    logic [27:0] sum;
    logic [7:0]  d;
    logic        st, s, lsb, g, rs;
    logic signed [9:0] e;
    logic [4:0]  lz;
    logic [24:0] m;
    integer i;
    r = 32'd0;
    if ((a[30:23] == 8'hFF && a[22:0] != 0) || (b[30:23] == 8'hFF && b[22:0] != 0)) begin
      r = CANON_NAN;
    end else if (a[30:23] == 8'hFF && b[30:23] == 8'hFF) begin
      r = (a[31] != b[31]) ? CANON_NAN : a;
    end else if (a[30:23] == 8'hFF) begin
      r = a;
    end else if (b[30:23] == 8'hFF) begin
      r = b;
    end else begin
      if (a[30:0] >= b[30:0]) begin x = a; y = b; end else begin x = b; y = a; end
      ex = (x[30:23] == 0) ? 8'd1 : x[30:23];
      ey = (y[30:23] == 0) ? 8'd1 : y[30:23];
      mx = {1'b0, (x[30:23] != 0), x[22:0], 2'b00};
      my = {1'b0, (y[30:23] != 0), y[22:0], 2'b00};
      d = ex - ey;
      st = 1'b0;
      if (d > 8'd26) begin
        st = |my; my = 27'd0;
      end else begin
        for (i = 0; i < 27; i++) if (i < d && my[i]) st = 1'b1;
        my = my >> d;
      end
      if (x[31] == y[31]) sum = {1'b0, mx} + {1'b0, my};
      else sum = {1'b0, mx} - {1'b0, my} - {27'd0, st};
      s = x[31];
      e = 10'(signed'({2'd0, ex}));
      if (sum == 0 && !st) begin
        r = (a[31] & b[31]) ? 32'h80000000 : 32'd0;
      end else begin
        if (sum[26]) begin
          rs = sum[0] | st;
          mr = sum[27:1]; mr[0] = mr[0] | rs; e = e + 10'sd1;
        end else begin
          mr = sum[26:0];
          lz = 5'd0;
          for (i = 0; i <= 25; i++) if (mr[i]) lz = 5'(25 - i);
          if (10'(signed'({5'd0, lz})) > e - 10'sd1) lz = 5'(e - 10'sd1);
          mr = mr << lz; e = e - 10'(signed'({5'd0, lz}));
          // bits shifted out of the smaller operand stay sticky below the guard
          mr[0] = mr[0] | st;
        end
        lsb = mr[2]; g = mr[1];
        m = {1'b0, mr[25:2]} + {24'd0, (g & (mr[0] | lsb))};
        if (m[24]) begin m = m >> 1; e = e + 10'sd1; end
        if (e >= 10'sd255) r = {s, 8'hFF, 23'd0};
        else if (!m[23]) r = {s, 8'd0, m[22:0]};
        else r = {s, e[7:0], m[22:0]};
      end
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// File: rtl/core/i8dot_datapath.sv
`default_nettype none
module i8dot_datapath (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire i8dot_pkg::dp_cmd_t   cmd,
  input  wire i8dot_pkg::in_beat_t  beat,
  output logic [31:0]               result
);
  logic [31:0] act, scale, bias, wval, acc, sum, alu, res;
  logic [31:0] op_a, op_b;

  // weight widened to fp32
  function automatic logic [31:0] i2f(input logic signed [7:0] v);
    logic [7:0] mg;
    logic [2:0] p;
    integer i;
    mg = v[7] ? 8'(-v) : 8'(v);
    p = 3'd0;
    for (i = 0; i < 8; i++) if (mg[i]) p = 3'(i);
    if (mg == 0) return 32'd0;
    return {v[7], 8'(8'd127 + {5'd0, p}), 23'((32'(mg) << (23 - p)) & 32'h7FFFFF)};
  endfunction

  // operand selection for the shared unit
  always_comb begin
    op_a = acc; op_b = act;
    unique case (cmd.op)
      i8dot_pkg::OP_MUL_ACT: begin op_a = act; op_b = wval; end
      i8dot_pkg::OP_ADD_SUM: begin op_a = sum; op_b = acc; end
      i8dot_pkg::OP_MUL_SCL: begin op_a = sum; op_b = scale; end
      i8dot_pkg::OP_ADD_BIA: begin op_a = acc; op_b = bias; end
      default: begin op_a = acc; op_b = act; end
    endcase
    if (cmd.op == i8dot_pkg::OP_MUL_ACT || cmd.op == i8dot_pkg::OP_MUL_SCL)
      alu = i8dot_pkg::fmul(op_a, op_b);
    else
      alu = i8dot_pkg::fadd(op_a, op_b);
  end

  // operand and intermediate registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      act <= beat.activation; wval <= i2f(beat.weight);
      scale <= beat.row_scale; bias <= beat.row_bias;
    end
    if (cmd.exec && (cmd.op == i8dot_pkg::OP_MUL_ACT || cmd.op == i8dot_pkg::OP_MUL_SCL))
      acc <= alu;
  end

  // running sum
  always_ff @(posedge clk) begin
    if (rst || cmd.clear) sum <= 32'd0;
    else if (cmd.exec && cmd.op == i8dot_pkg::OP_ADD_SUM) sum <= alu;
  end

  // output register, loaded by the bias add
  always_ff @(posedge clk) begin
    if (cmd.exec && cmd.op == i8dot_pkg::OP_ADD_BIA) res <= alu;
  end

  assign result = res;
endmodule
`default_nettype wire

// File: rtl/core/i8dot_ctrl.sv
`default_nettype none
module i8dot_ctrl #(
  parameter int MAX_ROW_LENGTH = 8192,
  parameter int MAX_ROWS = 65536
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_stall,
  output logic                    out_valid,
  input  wire logic               out_stall,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [0:0]         cfg_index,
  input  wire logic [31:0]        cfg_data,
  output i8dot_pkg::dp_cmd_t      cmd,
  output logic [15:0]             out_row
);
  typedef enum logic [4:0] {
    S_IDLE = 5'b00001, S_MUL = 5'b00010, S_ADD = 5'b00100,
    S_SCL  = 5'b01000, S_BIA = 5'b10000
  } state_t;

  state_t state, state_next;
  logic [13:0] row_length;
  logic [16:0] row_count;
  logic [16:0] elem, len_eff;
  logic [20:0] row, cnt_eff;
  logic        last, busy_out;

  // effective lengths: zero acts as one, large saturates
  always_comb begin
    len_eff = (row_length == 0) ? 17'd1 :
              (32'(row_length) > 32'(MAX_ROW_LENGTH)) ? 17'(MAX_ROW_LENGTH) : 17'(row_length);
    cnt_eff = (row_count == 0) ? 21'd1 :
              (32'(row_count) > 32'(MAX_ROWS)) ? 21'(MAX_ROWS) : 21'(row_count);
  end

  assign cfg_ready = 1'b1;
  assign in_stall  = (state != S_IDLE);
  assign busy_out  = out_valid && out_stall;

  // sequencer
  always_comb begin
    state_next = state;
    cmd = '{load: 1'b0, exec: 1'b0, op: i8dot_pkg::OP_MUL_ACT, clear: 1'b0};
    unique case (state)
      S_IDLE: begin
        cmd.load = in_valid && !in_stall;
        if (cmd.load) state_next = S_MUL;
      end
      S_MUL: begin
        cmd.exec = 1'b1; cmd.op = i8dot_pkg::OP_MUL_ACT; state_next = S_ADD;
      end
      S_ADD: begin
        cmd.exec = 1'b1; cmd.op = i8dot_pkg::OP_ADD_SUM;
        state_next = last ? S_SCL : S_IDLE;
      end
      S_SCL: begin
        cmd.exec = 1'b1; cmd.op = i8dot_pkg::OP_MUL_SCL; cmd.clear = 1'b0;
        state_next = S_BIA;
      end
      S_BIA: begin
        // wait here while the previous result is still held
        if (!busy_out) begin
          cmd.exec = 1'b1; cmd.op = i8dot_pkg::OP_ADD_BIA; cmd.clear = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  assign last = (elem + 17'd1 >= len_eff);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE; out_valid <= 1'b0; elem <= '0; row <= '0;
      row_length <= 14'd1; row_count <= 17'd1; out_row <= '0;
    end else begin
      state <= state_next;
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          i8dot_pkg::REG_ROW_LENGTH: row_length <= cfg_data[13:0];
          i8dot_pkg::REG_ROW_COUNT:  row_count  <= cfg_data[16:0];
          default: ;
        endcase
      end
      if (state == S_BIA && !busy_out) out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
      if (state == S_ADD && !last) elem <= elem + 17'd1;
      if (state == S_BIA && !busy_out) begin
        out_row <= row[15:0]; elem <= '0;
        row <= (row + 21'd1 >= cnt_eff) ? 21'd0 : row + 21'd1;
      end
    end
  end
endmodule
`default_nettype wire

// File: rtl/core/int8_weight_row_dot_product.sv
// int8 weight row dot product
// in channel: activation, weight, row_scale, row_bias beat under in_valid/in_stall.
// out channel: row_value, row_number beat under out_valid/out_stall.
// cfg channel: cfg_valid/cfg_ready, cfg_index 0 = row_length, 1 = row_count;
// they are to be written only while idle, which the block itself does not enforce.
// one shared fp32 unit does every multiply and add, at most one op per cycle:
// an element goes through accept, multiply and add into the sum, and a new
// beat is taken only once the previous element has gone back to idle.
// the last element of a row goes through accept, multiply, add, scale
// multiply and bias add; its result sits in the output register from the
// cycle after the bias add.
// the input stalls while an element is in flight; a result held by out_stall
// only blocks the next row's bias add, so the following row keeps accumulating.
// reset (rst, synchronous) clears the sum, counters and output valid,
// and sets both registers to one.
`default_nettype none
module int8_weight_row_dot_product #(
  parameter int MAX_ROW_LENGTH = 8192,
  parameter int MAX_ROWS = 65536
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire i8dot_pkg::in_beat_t  in_data,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output i8dot_pkg::out_beat_t      out_data,
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [0:0]           cfg_index,
  input  wire logic [31:0]          cfg_data
);
  i8dot_pkg::dp_cmd_t cmd;
  logic [31:0] result;
  logic [15:0] row;

  i8dot_ctrl #(.MAX_ROW_LENGTH(MAX_ROW_LENGTH), .MAX_ROWS(MAX_ROWS)) u_ctrl (
    .clk, .rst, .in_valid, .in_stall, .out_valid, .out_stall,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data, .cmd, .out_row(row)
  );

  i8dot_datapath u_dp (.clk, .rst, .cmd, .beat(in_data), .result);

  assign out_data = '{row_value: result, row_number: row};
endmodule
`default_nettype wire
